FILE: hdl/pht_pkg.sv
// Shared types and constants for the parallel handshake transmitter.
package pht_pkg;

    localparam int WORD_BITS_DEF = 7;
    localparam int RETRY_BITS    = 16;
    localparam int CNT_BITS      = RETRY_BITS + 1;
    localparam logic [RETRY_BITS-1:0] RETRY_RESET = 16'd100;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Register index (paddr / 4)
    localparam logic REG_RETRY_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT1 = 2'd1,
        PH_WAIT2 = 2'd2
    } phase_t;

endpackage

FILE: hdl/pht_in_if.sv
// Input channel: one poll interval per transaction.
interface pht_in_if #(
    parameter int WORD_BITS = pht_pkg::WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 word_valid;
    logic [WORD_BITS-1:0] data_word;
    logic                 word_last;
    logic                 ack_line;

    modport source (output valid, word_valid, data_word, word_last, ack_line, input ready);
    modport sink   (input valid, word_valid, data_word, word_last, ack_line, output ready);
endinterface

FILE: hdl/pht_out_if.sv
// Result channel: line levels and event flags after each poll interval.
interface pht_out_if #(
    parameter int WORD_BITS = pht_pkg::WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 ready_line;
    logic [WORD_BITS-1:0] data_lines;
    logic                 request_line;
    logic                 word_taken;
    logic                 frame_done;
    logic                 timed_out;
    logic                 busy_res;

    modport source (output valid, ready_line, data_lines, request_line, word_taken,
                    frame_done, timed_out, busy_res, input ready);
    modport sink   (input valid, ready_line, data_lines, request_line, word_taken,
                    frame_done, timed_out, busy_res, output ready);
endinterface

FILE: hdl/pht_apb_regs.sv
// APB register file holding the retry limit.
module pht_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pht_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [pht_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [pht_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output logic [pht_pkg::RETRY_BITS-1:0]     retry_limit
);
    logic [pht_pkg::RETRY_BITS-1:0] limit_reg;
    logic [pht_pkg::RETRY_BITS-1:0] limit_next;
    logic                           hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == pht_pkg::REG_RETRY_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && hit)
        begin
            limit_next = pwdata[pht_pkg::RETRY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= pht_pkg::RETRY_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata[pht_pkg::RETRY_BITS-1:0] = limit_reg;
        end
    end

    assign retry_limit = limit_reg;
endmodule

FILE: hdl/pht_core.sv
// Toggle handshake state machine with registered result.
module pht_core #(
    parameter int WORD_BITS = pht_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pht_pkg::RETRY_BITS-1:0] retry_limit,
    pht_in_if.sink                         in_ch,
    pht_out_if.source                      out_ch
);
    pht_pkg::phase_t                phase_reg, phase_next;
    logic                           request_reg, request_next;
    logic [pht_pkg::CNT_BITS-1:0]   retries_reg, retries_next;
    logic [WORD_BITS-1:0]           held_word_reg, held_word_next;
    logic                           held_last_reg, held_last_next;
    logic                           ready_lvl_reg, ready_lvl_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           taken_reg, taken_next;
    logic                           done_reg, done_next;
    logic                           tout_reg, tout_next;

    logic                           accept;
    logic                           ack_match;
    logic [pht_pkg::CNT_BITS-1:0]   retries_dec;
    logic [pht_pkg::CNT_BITS-1:0]   retries_load;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign ack_match    = (in_ch.ack_line == request_reg);
    assign retries_dec  = retries_reg - {{(pht_pkg::CNT_BITS-1){1'b0}}, (retries_reg != '0)};
    assign retries_load = {1'b0, retry_limit} + {{(pht_pkg::CNT_BITS-1){1'b0}}, 1'b1};

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        request_next   = request_reg;
        retries_next   = retries_reg;
        held_word_next = held_word_reg;
        held_last_next = held_last_reg;
        ready_lvl_next = ready_lvl_reg;
        if (accept)
        begin
            case (phase_reg)
                pht_pkg::PH_WAIT1, pht_pkg::PH_WAIT2:
                begin
                    if (ack_match)
                    begin
                        if (phase_reg == pht_pkg::PH_WAIT1)
                        begin
                            request_next = !request_reg;
                            retries_next = retries_load;
                            phase_next   = pht_pkg::PH_WAIT2;
                        end
                        else
                        begin
                            phase_next = pht_pkg::PH_IDLE;
                            if (held_last_reg)
                            begin
                                ready_lvl_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        retries_next = retries_dec;
                        if (retries_dec == '0)
                        begin
                            ready_lvl_next = 1'b0;
                            phase_next     = pht_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = pht_pkg::PH_IDLE;
                    if (in_ch.word_valid)
                    begin
                        held_word_next = in_ch.data_word;
                        held_last_next = in_ch.word_last;
                        ready_lvl_next = 1'b1;
                        request_next   = !request_reg;
                        retries_next   = retries_load;
                        phase_next     = pht_pkg::PH_WAIT1;
                    end
                end
            endcase
        end
    end

    // event flags and result valid
    always_comb
    begin
        taken_next     = taken_reg;
        done_next      = done_reg;
        tout_next      = tout_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (accept)
        begin
            out_valid_next = 1'b1;
            taken_next     = 1'b0;
            done_next      = 1'b0;
            tout_next      = 1'b0;
            case (phase_reg)
                pht_pkg::PH_WAIT1, pht_pkg::PH_WAIT2:
                begin
                    done_next = ack_match && (phase_reg == pht_pkg::PH_WAIT2) && held_last_reg;
                    tout_next = !ack_match && (retries_dec == '0);
                end
                default:
                begin
                    taken_next = in_ch.word_valid;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pht_pkg::PH_IDLE;
            request_reg   <= 1'b0;
            retries_reg   <= '0;
            held_word_reg <= '0;
            held_last_reg <= 1'b0;
            ready_lvl_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            taken_reg     <= 1'b0;
            done_reg      <= 1'b0;
            tout_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            request_reg   <= request_next;
            retries_reg   <= retries_next;
            held_word_reg <= held_word_next;
            held_last_reg <= held_last_next;
            ready_lvl_reg <= ready_lvl_next;
            out_valid_reg <= out_valid_next;
            taken_reg     <= taken_next;
            done_reg      <= done_next;
            tout_reg      <= tout_next;
        end
    end

    // Line levels come straight from state: state only moves on accept,
    // and accept is blocked while a result is stalled.
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.ready_line   = ready_lvl_reg;
    assign out_ch.data_lines   = held_word_reg;
    assign out_ch.request_line = request_reg;
    assign out_ch.word_taken   = taken_reg;
    assign out_ch.frame_done   = done_reg;
    assign out_ch.timed_out    = tout_reg;
    assign out_ch.busy_res     = (phase_reg == pht_pkg::PH_WAIT1) ||
                                 (phase_reg == pht_pkg::PH_WAIT2);
endmodule

FILE: hdl/parallel_handshake_transmitter.sv
// Top level of the parallel handshake transmitter.
//
//   channel   | dir | handshake      | contents
//   ----------+-----+----------------+------------------------------------------
//   in_ch     | in  | valid/ready    | word_valid, data_word, word_last, ack_line
//   out_ch    | out | valid/ready    | ready/data/request levels, event flags
//   apb       | in  | psel/penable   | retry_limit at byte address 0
//
// One transaction in = one poll interval = one result out.
// The handshake FSM updates on the accepting edge; the result appears the
// next cycle from the state and flag registers.
// in_ch.ready is high while the result register is empty or being taken,
// so a stalled output holds one result and stops intake until it drains.
// Reset (rst_n low, async) gives idle, request low, ready low, data zero,
// and retry_limit = 100.
module parallel_handshake_transmitter #(
    parameter int WORD_BITS = pht_pkg::WORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pht_in_if.sink                             in_ch,
    pht_out_if.source                          out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pht_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [pht_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [pht_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    // retry limit as read at the start of each acknowledge wait
    logic [pht_pkg::RETRY_BITS-1:0] retry_limit;

    pht_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .retry_limit (retry_limit)
    );

    // Two-phase toggle: toggle request, wait for ack == request, toggle
    // again, wait again; a mismatch count past the limit aborts the frame.
    pht_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .retry_limit (retry_limit),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );
endmodule

FILE: hdl/pht_checker.sv
// Port-level checks for the parallel handshake transmitter, bound to the top.
module pht_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic ready_line,
    input logic request_line,
    input logic word_taken,
    input logic frame_done,
    input logic timed_out,
    input logic busy_res
);
    // stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(request_line) && $stable(busy_res))
        else $error("result changed while stalled");

    // intake open whenever the result register is empty
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // a taken word starts a wait with ready raised
    a_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_taken |-> busy_res && ready_line && !frame_done && !timed_out)
        else $error("word taken without starting a transfer");

    // completion and abort leave the link idle with ready low
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_done || timed_out) |-> !busy_res && !ready_line)
        else $error("frame end with transfer still active");

    // request only toggles on an accepted interval
    a_req: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) |=> $stable(request_line))
        else $error("request toggled without an accepted transaction");
endmodule

bind parallel_handshake_transmitter pht_checker u_pht_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .ready_line   (out_ch.ready_line),
    .request_line (out_ch.request_line),
    .word_taken   (out_ch.word_taken),
    .frame_done   (out_ch.frame_done),
    .timed_out    (out_ch.timed_out),
    .busy_res     (out_ch.busy_res)
);
